// ===== hdl/vector_normalize_clamp_3d_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the vector normalize / clamp core.
// Concurrent checks are compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef VECTOR_NORMALIZE_CLAMP_3D_CORE_ASSERT_SVH
`define VECTOR_NORMALIZE_CLAMP_3D_CORE_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication, sampled on clk_i, disabled during reset.
`define VNC3D_ASSERT_IMP(lbl, pre, con) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (con)) \
    else $error("vnc3d: same-cycle check failed");
// Next-cycle implication, sampled on clk_i, disabled during reset.
`define VNC3D_ASSERT_NXT(lbl, pre, con) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (con)) \
    else $error("vnc3d: next-cycle check failed");
`else
`define VNC3D_ASSERT_IMP(lbl, pre, con)
`define VNC3D_ASSERT_NXT(lbl, pre, con)
`endif
`endif

// ===== hdl/vnc3d_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vnc3d_pkg
// Shared types and constants of the vector normalize / clamp core.
// ----------------------------------------------------------------------------
package vnc3d_pkg;

  localparam int unsigned CompW     = 32;
  localparam int unsigned NumW      = 64;
  localparam int unsigned SqrtSteps = 32;
  localparam int unsigned DivSteps  = 32;

  localparam logic [31:0] LimReset = 32'h0001_0000;

  // Command codes.
  localparam logic CmdNormalize = 1'b0;
  localparam logic CmdTrim      = 1'b1;

  // One classified item handed from the front to the back.
  typedef struct packed {
    logic [2:0][CompW-1:0] vec;
    logic [2:0][NumW-1:0]  num;
    logic [NumW-1:0]       sum;
    logic                  scale;
  } item_t;

  // Queue status.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // One stage of the square root pipeline.
  typedef struct packed {
    logic                  valid;
    logic [2:0][CompW-1:0] vec;
    logic [2:0][NumW-1:0]  num;
    logic                  scale;
    logic [NumW-1:0]       rad;
    logic [34:0]           rem;
    logic [CompW-1:0]      root;
  } sq_t;

  // One stage of the three-lane divider pipeline.
  typedef struct packed {
    logic                  valid;
    logic [2:0][CompW-1:0] vec;
    logic                  scale;
    logic [CompW-1:0]      len;
    logic [2:0][CompW-1:0] rem;
    logic [2:0][CompW-1:0] nq;
  } dv_t;

endpackage

// ===== hdl/vector_normalize_clamp_3d_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_normalize_clamp_3d_core
// Normalizes or length-limits signed Q16.16 3D vectors.
// ----------------------------------------------------------------------------
// Usage:
// The slave stream carries one vector per transfer: tdata holds x, y, z and
// tuser holds the command (0 normalize, 1 trim). The master stream returns
// one result per vector in the same order: tdata holds out_x, out_y, out_z
// and the floor length, tuser holds the clamped flag.
// The trim limit is written through cfg_we_i / cfg_wdata_i while idle.
// Throughput is one vector per cycle while the receiver does not stall. Each
// input transfer passes three front stages, one queue slot, a 32-step square
// root pipeline and a 32-step three-lane divider pipeline, one bit or digit
// per stage, and the output register before it reaches the master side.
// A stalled receiver freezes the back pipeline; the queue then fills and the
// front stops taking transfers once the queue is full.
// Reset clears all pipeline valids, empties the queue and sets the limit
// to 1.0.
// ----------------------------------------------------------------------------
`include "vector_normalize_clamp_3d_core_assert.svh"

module vector_normalize_clamp_3d_core #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_tvalid_i,
  output logic         s_tready_o,
  input  logic [95:0]  s_tdata_i,   // vec_x [31:0], vec_y [63:32], vec_z [95:64]
  input  logic         s_tuser_i,   // cmd [0]
  output logic         m_tvalid_o,
  input  logic         m_tready_i,
  output logic [127:0] m_tdata_o,   // out_x, out_y, out_z, length (32 bits each)
  output logic         m_tuser_o,   // clamped [0]
  input  logic         cfg_we_i,
  input  logic [31:0]  cfg_wdata_i
);

  logic [31:0]                      max_length_q;
  logic                             fr_valid, q_ready, bk_valid, bk_ready;
  vnc3d_pkg::item_t                 fr_item, bk_item;
  vnc3d_pkg::q_stat_t               q_stat;
  logic [2:0][vnc3d_pkg::CompW-1:0] out_vec;
  logic [31:0]                      out_len;

  // Limit register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_length_q <= vnc3d_pkg::LimReset;
    end else if (cfg_we_i) begin
      max_length_q <= cfg_wdata_i;
    end
  end

  vnc3d_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_tvalid_i),
    .in_ready_o   (s_tready_o),
    .cmd_i        (s_tuser_i),
    .vec_i        (s_tdata_i),
    .max_length_i (max_length_q),
    .out_valid_o  (fr_valid),
    .out_ready_i  (q_ready),
    .item_o       (fr_item)
  );

  vnc3d_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (q_ready),
    .item_i       (fr_item),
    .pop_valid_o  (bk_valid),
    .pop_ready_i  (bk_ready),
    .item_o       (bk_item),
    .stat_o       (q_stat)
  );

  vnc3d_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (bk_valid),
    .in_ready_o  (bk_ready),
    .item_i      (bk_item),
    .out_valid_o (m_tvalid_o),
    .out_ready_i (m_tready_i),
    .out_vec_o   (out_vec),
    .length_o    (out_len),
    .clamped_o   (m_tuser_o)
  );

  assign m_tdata_o = {out_len, out_vec};

  // A rescaled result always comes from a nonzero length.
  `VNC3D_ASSERT_IMP(a_clamp_len, m_tvalid_o && m_tuser_o, m_tdata_o[127:96] != 32'd0)
  // The queue is never full and empty at once.
  `VNC3D_ASSERT_IMP(a_queue_stat, 1'b1, !(q_stat.full && q_stat.empty))
  // A front item blocked by a full queue is still offered next cycle.
  `VNC3D_ASSERT_NXT(a_front_hold, fr_valid && q_stat.full, fr_valid)

endmodule

// ===== hdl/vnc3d_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vnc3d_front
// Accepts vectors, forms squares and numerators and decides on rescaling.
// ----------------------------------------------------------------------------
module vnc3d_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            cmd_i,
  input  logic [2:0][vnc3d_pkg::CompW-1:0] vec_i,
  input  logic [31:0]                     max_length_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output vnc3d_pkg::item_t                item_o
);

  logic adv;

  logic                             a_valid_q, a_cmd_q;
  logic [2:0][vnc3d_pkg::CompW-1:0] a_vec_q, a_mag_q;
  logic                             b_valid_q, b_cmd_q;
  logic [2:0][vnc3d_pkg::CompW-1:0] b_vec_q;
  logic [2:0][vnc3d_pkg::NumW-1:0]  b_sq_q, b_num_q;
  logic [vnc3d_pkg::NumW-1:0]       b_lim2_q;
  logic                             c_valid_q;
  vnc3d_pkg::item_t                 c_item_q;
  logic [vnc3d_pkg::NumW-1:0]       sum_d;

  // The whole front moves together unless its last stage is blocked.
  assign adv        = !c_valid_q || out_ready_i;
  assign in_ready_o = adv;

  // Stage A: register the transfer and take magnitudes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (adv) begin
      a_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_cmd_q <= cmd_i;
      a_vec_q <= vec_i;
      for (int i = 0; i < 3; i++) begin
        a_mag_q[i] <= vec_i[i][vnc3d_pkg::CompW-1] ? (~vec_i[i] + 32'd1) : vec_i[i];
      end
    end
  end

  // Stage B: squares, numerators and the squared limit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (adv) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b_cmd_q  <= a_cmd_q;
      b_vec_q  <= a_vec_q;
      b_lim2_q <= 64'(max_length_i) * 64'(max_length_i);
      for (int i = 0; i < 3; i++) begin
        b_sq_q[i]  <= 64'(a_mag_q[i]) * 64'(a_mag_q[i]);
        b_num_q[i] <= (a_cmd_q == vnc3d_pkg::CmdTrim) ?
                      64'(a_mag_q[i]) * 64'(max_length_i) :
                      {16'd0, a_mag_q[i], 16'd0};
      end
    end
  end

  // Stage C: sum of squares and the rescale decision.
  assign sum_d = b_sq_q[0] + b_sq_q[1] + b_sq_q[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
    end else if (adv) begin
      c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c_item_q.vec   <= b_vec_q;
      c_item_q.num   <= b_num_q;
      c_item_q.sum   <= sum_d;
      c_item_q.scale <= (b_cmd_q == vnc3d_pkg::CmdTrim) ? (sum_d > b_lim2_q)
                                                        : (sum_d != 64'd0);
    end
  end

  assign out_valid_o = c_valid_q;
  assign item_o      = c_item_q;

endmodule

// ===== hdl/vnc3d_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vnc3d_queue
// Short register queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module vnc3d_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_valid_i,
  output logic               push_ready_o,
  input  vnc3d_pkg::item_t   item_i,
  output logic               pop_valid_o,
  input  logic               pop_ready_i,
  output vnc3d_pkg::item_t   item_o,
  output vnc3d_pkg::q_stat_t stat_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  vnc3d_pkg::item_t mem_q [Depth];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [CntW-1:0]  cnt_q;
  logic             push, pop;

  assign stat_o.full  = (cnt_q == CntW'(Depth));
  assign stat_o.empty = (cnt_q == '0);
  assign push_ready_o = !stat_o.full;
  assign pop_valid_o  = !stat_o.empty;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign item_o       = mem_q[rd_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (pop) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

// ===== hdl/vnc3d_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vnc3d_back
// Square root pipeline, three-lane divider pipeline and the output register.
// ----------------------------------------------------------------------------
module vnc3d_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  vnc3d_pkg::item_t                 item_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [2:0][vnc3d_pkg::CompW-1:0] out_vec_o,
  output logic [vnc3d_pkg::CompW-1:0]      length_o,
  output logic                             clamped_o
);

  localparam int unsigned SqN = vnc3d_pkg::SqrtSteps;
  localparam int unsigned DvN = vnc3d_pkg::DivSteps;

  vnc3d_pkg::sq_t                   sq_q [SqN+1];
  vnc3d_pkg::dv_t                   dv_q [DvN+1];
  logic                             o_valid_q, o_clamped_q;
  logic [2:0][vnc3d_pkg::CompW-1:0] o_vec_q;
  logic [vnc3d_pkg::CompW-1:0]      o_len_q;
  logic                             adv;
  vnc3d_pkg::dv_t                   dv_init;

  // One digit of the floor square root, two radicand bits per step.
  function automatic vnc3d_pkg::sq_t sqrt_step(vnc3d_pkg::sq_t s);
    vnc3d_pkg::sq_t n;
    logic [34:0]    r;
    logic [34:0]    t;
    n     = s;
    r     = {s.rem[32:0], s.rad[63:62]};
    t     = {1'b0, s.root, 2'b01};
    n.rad = {s.rad[61:0], 2'b00};
    if (r >= t) begin
      n.rem  = r - t;
      n.root = {s.root[30:0], 1'b1};
    end else begin
      n.rem  = r;
      n.root = {s.root[30:0], 1'b0};
    end
    return n;
  endfunction

  // One quotient bit in each of the three lanes.
  function automatic vnc3d_pkg::dv_t div_step(vnc3d_pkg::dv_t s);
    vnc3d_pkg::dv_t n;
    logic [32:0]    r;
    logic [32:0]    d;
    logic           b;
    n = s;
    d = {1'b0, s.len};
    for (int i = 0; i < 3; i++) begin
      r = {s.rem[i], s.nq[i][31]};
      b = (r >= d);
      if (b) begin
        r = r - d;
      end
      n.rem[i] = r[31:0];
      n.nq[i]  = {s.nq[i][30:0], b};
    end
    return n;
  endfunction

  // The back moves as one unless the output register holds a waiting result.
  assign adv        = !o_valid_q || out_ready_i;
  assign in_ready_o = adv;

  // Divider entry state from the finished root.
  always_comb begin
    dv_init.valid = sq_q[SqN].valid;
    dv_init.vec   = sq_q[SqN].vec;
    dv_init.scale = sq_q[SqN].scale;
    dv_init.len   = sq_q[SqN].root;
    for (int i = 0; i < 3; i++) begin
      dv_init.rem[i] = sq_q[SqN].num[i][63:32];
      dv_init.nq[i]  = sq_q[SqN].num[i][31:0];
    end
  end

  // Square root and divider stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= SqN; k++) begin
        sq_q[k] <= '0;
      end
      for (int k = 0; k <= DvN; k++) begin
        dv_q[k] <= '0;
      end
    end else if (adv) begin
      sq_q[0].valid <= in_valid_i;
      sq_q[0].vec   <= item_i.vec;
      sq_q[0].num   <= item_i.num;
      sq_q[0].scale <= item_i.scale;
      sq_q[0].rad   <= item_i.sum;
      sq_q[0].rem   <= '0;
      sq_q[0].root  <= '0;
      for (int k = 0; k < SqN; k++) begin
        sq_q[k+1] <= sqrt_step(sq_q[k]);
      end
      dv_q[0] <= dv_init;
      for (int k = 0; k < DvN; k++) begin
        dv_q[k+1] <= div_step(dv_q[k]);
      end
    end
  end

  // Output register: restore signs or pass the vector unchanged.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
    end else if (adv) begin
      o_valid_q <= dv_q[DvN].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      o_len_q     <= dv_q[DvN].len;
      o_clamped_q <= dv_q[DvN].scale;
      for (int i = 0; i < 3; i++) begin
        if (!dv_q[DvN].scale) begin
          o_vec_q[i] <= dv_q[DvN].vec[i];
        end else if (dv_q[DvN].vec[i][31]) begin
          o_vec_q[i] <= ~dv_q[DvN].nq[i] + 32'd1;
        end else begin
          o_vec_q[i] <= dv_q[DvN].nq[i];
        end
      end
    end
  end

  assign out_valid_o = o_valid_q;
  assign out_vec_o   = o_vec_q;
  assign length_o    = o_len_q;
  assign clamped_o   = o_clamped_q;

endmodule

// ===== tb/vector_normalize_clamp_3d_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_normalize_clamp_3d_core_tb
// Self-checking bench for the vector normalize / clamp core. A built-in
// predictor computes each result from every accepted vector. Results are
// compared in order, while both stream sides idle at random in four of the six random phases.
// ----------------------------------------------------------------------------
module vector_normalize_clamp_3d_core_tb;

  localparam int unsigned CycleLimit = 2000000;

  typedef struct packed {
    logic [31:0] ox;
    logic [31:0] oy;
    logic [31:0] oz;
    logic [31:0] len;
    logic        clamped;
  } vec_result_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_tvalid_i;
  logic         s_tready_o;
  logic [95:0]  s_tdata_i;
  logic         s_tuser_i;
  logic         m_tvalid_o;
  logic         m_tready_i;
  logic [127:0] m_tdata_o;
  logic         m_tuser_o;
  logic         cfg_we_i;
  logic [31:0]  cfg_wdata_i;

  logic [31:0]  limit_q;
  vec_result_t  pending_results[$];
  int unsigned  fail_cnt;
  int unsigned  cycle_cnt;
  int unsigned  hold_cnt;
  bit           stall_rand;

  vector_normalize_clamp_3d_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_tvalid_i),
    .s_tready_o  (s_tready_o),
    .s_tdata_i   (s_tdata_i),
    .s_tuser_i   (s_tuser_i),
    .m_tvalid_o  (m_tvalid_o),
    .m_tready_i  (m_tready_i),
    .m_tdata_o   (m_tdata_o),
    .m_tuser_o   (m_tuser_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Floor square root, one result bit per step.
  function automatic logic [31:0] floor_sqrt(input logic [63:0] n);
    logic [63:0] root;
    logic [63:0] trial;
    int i;
    root = 64'd0;
    for (i = 31; i >= 0; i--) begin
      trial = root | (64'd1 << i);
      if (trial * trial <= n) root = trial;
    end
    return root[31:0];
  endfunction

  // Predict the result of one vector under the current limit.
  function automatic vec_result_t predict_vector(input logic cmd, input logic [95:0] v);
    vec_result_t r;
    logic [63:0] mag[3];
    logic [63:0] sum;
    logic [63:0] num;
    logic [63:0] q;
    logic [63:0] lim;
    logic        rescale;
    int i;
    sum = 64'd0;
    for (i = 0; i < 3; i++) begin
      mag[i] = v[32*i+31] ? (64'd0 - {{32{1'b1}}, v[32*i +: 32]}) : {32'd0, v[32*i +: 32]};
      sum += mag[i] * mag[i];
    end
    r.len = floor_sqrt(sum);
    lim = {32'd0, limit_q};
    rescale = (cmd == vnc3d_pkg::CmdNormalize) ? (r.len != 0)
                                               : ((sum > lim * lim) && (r.len != 0));
    r.clamped = rescale;
    for (i = 0; i < 3; i++) begin
      q = {32'd0, v[32*i +: 32]};
      if (rescale) begin
        num = (cmd == vnc3d_pkg::CmdNormalize) ? (mag[i] << 16) : (mag[i] * lim);
        q = num / {32'd0, r.len};
        if (v[32*i+31]) q = 64'd0 - q;
      end
      case (i)
        0: r.ox = q[31:0];
        1: r.oy = q[31:0];
        default: r.oz = q[31:0];
      endcase
    end
    return r;
  endfunction

  // Random gap: mostly short, now and then long.
  function automatic int unsigned gap_len();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Offer one vector; valid stays high into the next call when no gap follows.
  task automatic send_vector(input logic cmd, input logic [95:0] v);
    int unsigned g;
    g = stall_rand ? gap_len() : 0;
    if (g != 0) begin
      s_tvalid_i <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tdata_i  <= v;
    s_tuser_i  <= cmd;
    @(posedge clk_i);
    while (!s_tready_o) @(posedge clk_i);
    pending_results.push_back(predict_vector(cmd, v));
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    s_tvalid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (80) @(negedge clk_i);
  endtask

  task automatic write_limit(input logic [31:0] val);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= val;
    limit_q      = val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [31:0] rand_comp();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(65535) - 32768;
      3: return ($urandom_range(1) != 0) ? 32'h0 : 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_limit();
    case ($urandom_range(3))
      0: return $urandom_range(200000);
      1: return $urandom;
      default: return $urandom_range(32'h0400_0000);
    endcase
  endfunction

  // Edges of the fields: zero, unit axes, extreme components, both commands.
  task automatic test_directed();
    logic [31:0] edge_vals[6];
    int i;
    edge_vals = '{32'h0, 32'h0001_0000, 32'hffff_0000, 32'h8000_0000,
                  32'h7fff_ffff, 32'h1};
    stall_rand = 1'b0;
    send_vector(vnc3d_pkg::CmdNormalize, 96'd0);
    send_vector(vnc3d_pkg::CmdTrim, 96'd0);
    for (i = 0; i < 6; i++) begin
      send_vector(vnc3d_pkg::CmdNormalize,
                  {edge_vals[(i+2)%6], edge_vals[(i+1)%6], edge_vals[i]});
      send_vector(vnc3d_pkg::CmdTrim, {edge_vals[i], edge_vals[i], edge_vals[i]});
    end
    send_vector(vnc3d_pkg::CmdNormalize, {3{32'h8000_0000}});
    send_vector(vnc3d_pkg::CmdTrim, {3{32'h7fff_ffff}});
    // Exactly on the limit passes unchanged; just over it is trimmed.
    send_vector(vnc3d_pkg::CmdTrim, {32'h0, 32'h0, 32'h0001_0000});
    send_vector(vnc3d_pkg::CmdTrim, {32'h0, 32'h0, 32'h0001_0001});
  endtask

  // Trim under the limit extremes: zero and all ones.
  task automatic test_limit_extremes();
    int i;
    write_limit(32'h0);
    for (i = 0; i < 8; i++)
      send_vector(vnc3d_pkg::CmdTrim, {rand_comp(), rand_comp(), rand_comp()});
    send_vector(vnc3d_pkg::CmdTrim, {32'h0, 32'h0, 32'h1});
    write_limit(32'hffff_ffff);
    for (i = 0; i < 8; i++)
      send_vector(vnc3d_pkg::CmdTrim, {rand_comp(), rand_comp(), rand_comp()});
    send_vector(vnc3d_pkg::CmdTrim, {3{32'h8000_0000}});
  endtask

  // Random vectors and commands over several limits.
  task automatic test_random();
    int p;
    int i;
    for (p = 0; p < 6; p++) begin
      write_limit(rand_limit());
      stall_rand = (p % 3) != 0;
      for (i = 0; i < 300; i++)
        send_vector($urandom_range(1), {rand_comp(), rand_comp(), rand_comp()});
    end
  endtask

  // Result stream: stall runs of random length, mostly short and a few long.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_cnt != 0) begin
        m_tready_i <= 1'b0;
        hold_cnt   <= hold_cnt - 1;
      end else if (stall_rand && ($urandom_range(3) == 0)) begin
        m_tready_i <= 1'b0;
        hold_cnt   <= gap_len();
      end else begin
        m_tready_i <= 1'b1;
      end
    end
  end

  // In-order compare of every result transfer.
  always @(posedge clk_i) begin
    vec_result_t exp_r;
    vec_result_t got_r;
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      got_r = {m_tdata_o[31:0], m_tdata_o[63:32], m_tdata_o[95:64], m_tdata_o[127:96],
               m_tuser_o};
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got_r);
        fail_cnt++;
      end else begin
        exp_r = pending_results.pop_front();
        if (got_r.ox !== exp_r.ox)
          $display("%0t: out_x expected %h actual %h", $time, exp_r.ox, got_r.ox);
        if (got_r.oy !== exp_r.oy)
          $display("%0t: out_y expected %h actual %h", $time, exp_r.oy, got_r.oy);
        if (got_r.oz !== exp_r.oz)
          $display("%0t: out_z expected %h actual %h", $time, exp_r.oz, got_r.oz);
        if (got_r.len !== exp_r.len)
          $display("%0t: length expected %h actual %h", $time, exp_r.len, got_r.len);
        if (got_r.clamped !== exp_r.clamped)
          $display("%0t: clamped expected %b actual %b", $time, exp_r.clamped,
                   got_r.clamped);
        if (got_r !== exp_r) fail_cnt++;
      end
    end
  end

  initial begin
    rst_ni      = 1'b0;
    s_tvalid_i  = 1'b0;
    s_tdata_i   = '0;
    s_tuser_i   = 1'b0;
    m_tready_i  = 1'b1;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    limit_q     = vnc3d_pkg::LimReset;
    fail_cnt    = 0;
    cycle_cnt   = 0;
    hold_cnt    = 0;
    stall_rand  = 1'b0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_limit_extremes();
    test_random();
    drain_results();
    if (fail_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
